FILE: design/cau_pkg.sv
package cau_pkg;

    // Fraction bits of the Q format on all operand and result parts
    localparam int FRAC_BITS = 16;
    // Quotient bits produced by the divider; anything at or above 2^QW saturates
    localparam int QW = 33;
    // Low magnitude bits the divider still has to shift in
    localparam int NLW = QW - FRAC_BITS;
    // Full-width sum of two 64-bit products
    localparam int SW = 66;

    typedef enum logic [2:0] {
        MODE_ADD = 3'd0,
        MODE_SUB = 3'd1,
        MODE_MUL = 3'd2,
        MODE_DIV = 3'd3,
        MODE_EQ  = 3'd4,
        MODE_NE  = 3'd5
    } mode_t;

    localparam logic [1:0] ST_OK  = 2'd0;
    localparam logic [1:0] ST_DZ  = 2'd1;
    localparam logic [1:0] ST_SAT = 2'd2;

    // Side information that rides along the divider stages
    typedef struct packed {
        logic             is_div;
        logic             dz;
        logic             neg_r;
        logic             neg_i;
        logic             ovf_r;
        logic             ovf_i;
        logic [NLW-1:0]   low_r;
        logic [NLW-1:0]   low_i;
        logic [31:0]      pre_re;
        logic [31:0]      pre_im;
        logic             pre_cmp;
        logic [1:0]       pre_st;
    } side_t;

    // One divider lane: partial remainder and quotient bits so far
    typedef struct packed {
        logic [63:0]   rem;
        logic [QW-1:0] quo;
    } lane_t;

    // Apply sign to a magnitude and clamp to 32 bits; returns {sat, value}
    function automatic logic [32:0] pack_sat(input logic neg, input logic [63:0] mag);
        logic [32:0] r;
        if (neg) begin
            if (mag > 64'h0000_0000_8000_0000) r = {1'b1, 32'h8000_0000};
            else r = {1'b0, 32'(~mag[31:0] + 32'd1)};
        end else begin
            if (mag > 64'h0000_0000_7FFF_FFFF) r = {1'b1, 32'h7FFF_FFFF};
            else r = {1'b0, mag[31:0]};
        end
        return r;
    endfunction

    // One restoring division step
    function automatic lane_t div_step(input lane_t l, input logic nbit,
                                       input logic [63:0] den);
        logic [64:0] t;
        logic        ge;
        lane_t       r;
        t = {l.rem, nbit};
        ge = (t >= {1'b0, den});
        r.rem = ge ? 64'(t - {1'b0, den}) : t[63:0];
        r.quo = {l.quo[QW-2:0], ge};
        return r;
    endfunction

endpackage

FILE: design/cau_front.sv
module cau_front (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  en,
    input  logic                  in_valid,
    input  logic [2:0]            mode,
    input  logic signed [31:0]    a_real,
    input  logic signed [31:0]    a_imag,
    input  logic signed [31:0]    b_real,
    input  logic signed [31:0]    b_imag,
    output logic                  out_valid,
    output cau_pkg::side_t        side,
    output logic [63:0]           den,
    output cau_pkg::lane_t        lane_r,
    output cau_pkg::lane_t        lane_i
);

    // Stage A: products, squares, plain sums, equality
    logic                   va_reg;
    cau_pkg::mode_t         mode_a_reg;
    logic signed [63:0]     prr_a_reg, pii_a_reg, pri_a_reg, pir_a_reg;
    logic signed [63:0]     sqr_a_reg, sqi_a_reg;
    logic signed [32:0]     sre_a_reg, sim_a_reg;
    logic                   eq_a_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) va_reg <= 1'b0;
        else if (en) va_reg <= in_valid;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            mode_a_reg <= cau_pkg::mode_t'(mode);
            prr_a_reg  <= a_real * b_real;
            pii_a_reg  <= a_imag * b_imag;
            pri_a_reg  <= a_real * b_imag;
            pir_a_reg  <= a_imag * b_real;
            sqr_a_reg  <= b_real * b_real;
            sqi_a_reg  <= b_imag * b_imag;
            if (cau_pkg::mode_t'(mode) == cau_pkg::MODE_SUB) begin
                sre_a_reg <= 33'(a_real) - 33'(b_real);
                sim_a_reg <= 33'(a_imag) - 33'(b_imag);
            end else begin
                sre_a_reg <= 33'(a_real) + 33'(b_real);
                sim_a_reg <= 33'(a_imag) + 33'(b_imag);
            end
            eq_a_reg <= (a_real == b_real) && (a_imag == b_imag);
        end
    end

    // Stage B: full-width signed sums and divisor energy
    logic                        vb_reg;
    cau_pkg::mode_t              mode_b_reg;
    logic signed [cau_pkg::SW-1:0] sre_b_reg, sim_b_reg, sre_b_next, sim_b_next;
    logic [63:0]                 den_b_reg;
    logic                        eq_b_reg;

    always_comb begin
        case (mode_a_reg)
            cau_pkg::MODE_ADD, cau_pkg::MODE_SUB: begin
                sre_b_next = cau_pkg::SW'(sre_a_reg);
                sim_b_next = cau_pkg::SW'(sim_a_reg);
            end
            cau_pkg::MODE_MUL: begin
                sre_b_next = cau_pkg::SW'(prr_a_reg) - cau_pkg::SW'(pii_a_reg);
                sim_b_next = cau_pkg::SW'(pri_a_reg) + cau_pkg::SW'(pir_a_reg);
            end
            cau_pkg::MODE_DIV: begin
                sre_b_next = cau_pkg::SW'(prr_a_reg) + cau_pkg::SW'(pii_a_reg);
                sim_b_next = cau_pkg::SW'(pir_a_reg) - cau_pkg::SW'(pri_a_reg);
            end
            default: begin
                sre_b_next = '0;
                sim_b_next = '0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) vb_reg <= 1'b0;
        else if (en) vb_reg <= va_reg;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            mode_b_reg <= mode_a_reg;
            sre_b_reg  <= sre_b_next;
            sim_b_reg  <= sim_b_next;
            den_b_reg  <= $unsigned(sqr_a_reg) + $unsigned(sqi_a_reg);
            eq_b_reg   <= eq_a_reg;
        end
    end

    // Stage C: sign and magnitude
    logic            vc_reg;
    cau_pkg::mode_t  mode_c_reg;
    logic            neg_r_c_reg, neg_i_c_reg;
    logic [63:0]     mag_r_c_reg, mag_i_c_reg;
    logic [63:0]     den_c_reg;
    logic            dz_c_reg, eq_c_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) vc_reg <= 1'b0;
        else if (en) vc_reg <= vb_reg;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            mode_c_reg  <= mode_b_reg;
            neg_r_c_reg <= sre_b_reg[cau_pkg::SW-1];
            neg_i_c_reg <= sim_b_reg[cau_pkg::SW-1];
            mag_r_c_reg <= sre_b_reg[cau_pkg::SW-1] ? 64'(-sre_b_reg) : sre_b_reg[63:0];
            mag_i_c_reg <= sim_b_reg[cau_pkg::SW-1] ? 64'(-sim_b_reg) : sim_b_reg[63:0];
            den_c_reg   <= den_b_reg;
            dz_c_reg    <= (den_b_reg == 64'd0);
            eq_c_reg    <= eq_b_reg;
        end
    end

    // Stage D: finish non-divide results, seed the divider
    logic            vd_reg;
    cau_pkg::side_t  side_reg, side_next;
    logic [63:0]     den_reg;
    cau_pkg::lane_t  lr_reg, li_reg, lr_next, li_next;
    logic [63:0]     ms_r, ms_i;
    logic [32:0]     pk_r, pk_i;

    always_comb begin
        ms_r = (mode_c_reg == cau_pkg::MODE_MUL) ? (mag_r_c_reg >> cau_pkg::FRAC_BITS)
                                                 : mag_r_c_reg;
        ms_i = (mode_c_reg == cau_pkg::MODE_MUL) ? (mag_i_c_reg >> cau_pkg::FRAC_BITS)
                                                 : mag_i_c_reg;
        pk_r = cau_pkg::pack_sat(neg_r_c_reg, ms_r);
        pk_i = cau_pkg::pack_sat(neg_i_c_reg, ms_i);

        // first remainder is the numerator above the quotient field
        lr_next.rem = mag_r_c_reg >> (cau_pkg::QW - cau_pkg::FRAC_BITS);
        li_next.rem = mag_i_c_reg >> (cau_pkg::QW - cau_pkg::FRAC_BITS);
        lr_next.quo = '0;
        li_next.quo = '0;

        side_next.is_div  = (mode_c_reg == cau_pkg::MODE_DIV);
        side_next.dz      = dz_c_reg;
        side_next.neg_r   = neg_r_c_reg;
        side_next.neg_i   = neg_i_c_reg;
        side_next.ovf_r   = (lr_next.rem >= den_c_reg);
        side_next.ovf_i   = (li_next.rem >= den_c_reg);
        side_next.low_r   = mag_r_c_reg[cau_pkg::NLW-1:0];
        side_next.low_i   = mag_i_c_reg[cau_pkg::NLW-1:0];
        side_next.pre_re  = '0;
        side_next.pre_im  = '0;
        side_next.pre_cmp = 1'b0;
        side_next.pre_st  = cau_pkg::ST_OK;
        case (mode_c_reg)
            cau_pkg::MODE_ADD, cau_pkg::MODE_SUB, cau_pkg::MODE_MUL: begin
                side_next.pre_re = pk_r[31:0];
                side_next.pre_im = pk_i[31:0];
                side_next.pre_st = (pk_r[32] | pk_i[32]) ? cau_pkg::ST_SAT : cau_pkg::ST_OK;
            end
            cau_pkg::MODE_DIV: begin
                side_next.pre_st = dz_c_reg ? cau_pkg::ST_DZ : cau_pkg::ST_OK;
            end
            cau_pkg::MODE_EQ: side_next.pre_cmp = eq_c_reg;
            cau_pkg::MODE_NE: side_next.pre_cmp = !eq_c_reg;
            default: side_next.pre_cmp = 1'b0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) vd_reg <= 1'b0;
        else if (en) vd_reg <= vc_reg;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            side_reg <= side_next;
            den_reg  <= den_c_reg;
            lr_reg   <= lr_next;
            li_reg   <= li_next;
        end
    end

    assign out_valid = vd_reg;
    assign side      = side_reg;
    assign den       = den_reg;
    assign lane_r    = lr_reg;
    assign lane_i    = li_reg;

endmodule

FILE: design/cau_divider.sv
module cau_divider (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            en,
    input  logic            in_valid,
    input  cau_pkg::side_t  side_in,
    input  logic [63:0]     den_in,
    input  cau_pkg::lane_t  lane_r_in,
    input  cau_pkg::lane_t  lane_i_in,
    output logic            out_valid,
    output cau_pkg::side_t  side_out,
    output cau_pkg::lane_t  lane_r_out,
    output cau_pkg::lane_t  lane_i_out
);

    // One quotient bit per stage, real and imaginary lanes side by side
    logic            v_reg    [cau_pkg::QW];
    cau_pkg::side_t  side_reg [cau_pkg::QW];
    logic [63:0]     den_reg  [cau_pkg::QW];
    cau_pkg::lane_t  lr_reg   [cau_pkg::QW];
    cau_pkg::lane_t  li_reg   [cau_pkg::QW];

    for (genvar k = 0; k < cau_pkg::QW; k++) begin : g_stage
        localparam int J = cau_pkg::QW - 1 - k;
        logic            pv;
        cau_pkg::side_t  ps;
        logic [63:0]     pd;
        cau_pkg::lane_t  plr, pli;
        logic            nb_r, nb_i;

        if (k == 0) begin : g_first
            assign pv  = in_valid;
            assign ps  = side_in;
            assign pd  = den_in;
            assign plr = lane_r_in;
            assign pli = lane_i_in;
        end else begin : g_next
            assign pv  = v_reg[k-1];
            assign ps  = side_reg[k-1];
            assign pd  = den_reg[k-1];
            assign plr = lr_reg[k-1];
            assign pli = li_reg[k-1];
        end

        // numerator bit below the fraction point is zero
        if (J >= cau_pkg::FRAC_BITS) begin : g_bit
            assign nb_r = ps.low_r[J-cau_pkg::FRAC_BITS];
            assign nb_i = ps.low_i[J-cau_pkg::FRAC_BITS];
        end else begin : g_zero
            assign nb_r = 1'b0;
            assign nb_i = 1'b0;
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) v_reg[k] <= 1'b0;
            else if (en) v_reg[k] <= pv;
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                side_reg[k] <= ps;
                den_reg[k]  <= pd;
                lr_reg[k]   <= cau_pkg::div_step(plr, nb_r, pd);
                li_reg[k]   <= cau_pkg::div_step(pli, nb_i, pd);
            end
        end
    end

    assign out_valid  = v_reg[cau_pkg::QW-1];
    assign side_out   = side_reg[cau_pkg::QW-1];
    assign lane_r_out = lr_reg[cau_pkg::QW-1];
    assign lane_i_out = li_reg[cau_pkg::QW-1];

endmodule

FILE: design/cau_back.sv
module cau_back (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            en,
    input  logic            in_valid,
    input  cau_pkg::side_t  side,
    input  cau_pkg::lane_t  lane_r,
    input  cau_pkg::lane_t  lane_i,
    output logic            out_valid,
    output logic [31:0]     res_real,
    output logic [31:0]     res_imag,
    output logic            compare_true,
    output logic [1:0]      status
);

    logic        out_valid_reg;
    logic [31:0] re_reg, im_reg, re_next, im_next;
    logic        cmp_reg;
    logic [1:0]  st_reg, st_next;
    logic [32:0] pk_r, pk_i;
    logic        sat_r, sat_i;

    // Sign, saturate and select the final result
    always_comb begin
        pk_r = cau_pkg::pack_sat(side.neg_r, 64'(lane_r.quo));
        pk_i = cau_pkg::pack_sat(side.neg_i, 64'(lane_i.quo));
        sat_r = side.ovf_r | pk_r[32];
        sat_i = side.ovf_i | pk_i[32];
        if (side.is_div && !side.dz) begin
            re_next = side.ovf_r ? (side.neg_r ? 32'h8000_0000 : 32'h7FFF_FFFF) : pk_r[31:0];
            im_next = side.ovf_i ? (side.neg_i ? 32'h8000_0000 : 32'h7FFF_FFFF) : pk_i[31:0];
            st_next = (sat_r | sat_i) ? cau_pkg::ST_SAT : cau_pkg::ST_OK;
        end else begin
            re_next = side.pre_re;
            im_next = side.pre_im;
            st_next = side.pre_st;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) out_valid_reg <= 1'b0;
        else if (en) out_valid_reg <= in_valid;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            re_reg  <= re_next;
            im_reg  <= im_next;
            cmp_reg <= side.pre_cmp;
            st_reg  <= st_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign res_real     = re_reg;
    assign res_imag     = im_reg;
    assign compare_true = cmp_reg;
    assign status       = st_reg;

endmodule

FILE: design/complex_arithmetic_unit.sv
// Complex ALU on signed Q16.16 operands.
// Input stream: one transfer carries operands a and b and the operation code.
//   s_tuser selects add, subtract, multiply, divide, equal or not equal.
// Output stream: one transfer per input transfer, in order, holding the
//   result parts, the compare outcome and a status (ok, divide by zero,
//   saturated).
// Path: products, sums and magnitudes in stages A to D, restoring
//   division (one quotient bit per stage), one output register. All modes
//   take the same path.
// Throughput: one transfer per cycle while the receiver keeps m_tready high.
// Stall: with m_tvalid high and m_tready low the whole pipeline freezes and
//   s_tready drops in the same cycle; nothing is dropped or repeated.
// Reset: aresetn low for one clock empties the pipeline; m_tvalid goes low
//   and s_tready goes high.
module complex_arithmetic_unit (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_tvalid,
    output logic          s_tready,
    input  logic [127:0]  s_tdata,   // a_real, a_imag, b_real, b_imag
    input  logic [2:0]    s_tuser,   // mode
    output logic          m_tvalid,
    input  logic          m_tready,
    output logic [63:0]   m_tdata,   // res_real, res_imag
    output logic [2:0]    m_tuser    // compare_true, status
);

    logic            en;
    logic            f_valid, d_valid;
    cau_pkg::side_t  f_side, d_side;
    logic [63:0]     f_den;
    cau_pkg::lane_t  f_lr, f_li, d_lr, d_li;
    logic [31:0]     res_real, res_imag;
    logic            compare_true;
    logic [1:0]      status;

    // Pipeline advances unless a result is held at the output
    assign en       = !m_tvalid || m_tready;
    assign s_tready = en;

    cau_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (s_tvalid),
        .mode      (s_tuser),
        .a_real    ($signed(s_tdata[31:0])),
        .a_imag    ($signed(s_tdata[63:32])),
        .b_real    ($signed(s_tdata[95:64])),
        .b_imag    ($signed(s_tdata[127:96])),
        .out_valid (f_valid),
        .side      (f_side),
        .den       (f_den),
        .lane_r    (f_lr),
        .lane_i    (f_li)
    );

    cau_divider u_div (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .en         (en),
        .in_valid   (f_valid),
        .side_in    (f_side),
        .den_in     (f_den),
        .lane_r_in  (f_lr),
        .lane_i_in  (f_li),
        .out_valid  (d_valid),
        .side_out   (d_side),
        .lane_r_out (d_lr),
        .lane_i_out (d_li)
    );

    cau_back u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .en           (en),
        .in_valid     (d_valid),
        .side         (d_side),
        .lane_r       (d_lr),
        .lane_i       (d_li),
        .out_valid    (m_tvalid),
        .res_real     (res_real),
        .res_imag     (res_imag),
        .compare_true (compare_true),
        .status       (status)
    );

    assign m_tdata = {res_imag, res_real};
    assign m_tuser = {status, compare_true};

endmodule

FILE: design/cau_checker.sv
module cau_checker (
    input logic          aclk,
    input logic          aresetn,
    input logic          s_tvalid,
    input logic          s_tready,
    input logic [127:0]  s_tdata,
    input logic [2:0]    s_tuser,
    input logic          m_tvalid,
    input logic          m_tready,
    input logic [63:0]   m_tdata,
    input logic [2:0]    m_tuser
);

    // Input side is ready exactly when the output register can move
    a_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready == (!m_tvalid || m_tready))
        else $error("s_tready does not follow output stall");

    // A stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result changed");

    // Reset empties the pipeline
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("m_tvalid high after reset");

    // A true compare outcome and divide by zero carry zero result parts
    a_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser[0] || m_tuser[2:1] == 2'd1) |-> m_tdata == 64'd0)
        else $error("nonzero result with compare or divide by zero");

    // Status code 3 never appears
    a_status: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tuser[2:1] != 2'd3)
        else $error("invalid status code");

endmodule

bind complex_arithmetic_unit cau_checker u_cau_checker (.*);

FILE: verif/tb_top.sv
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LATENCY = 38;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int N_RANDOM = 1100;

    typedef struct {
        logic [2:0]  mode;
        logic [31:0] ar, ai, br, bi;
    } operands_t;

    typedef struct {
        logic [31:0] re, im;
        logic        cmp;
        logic [1:0]  st;
    } cplx_result_t;

    // directed stimulus row; has_exp marks rows with a typed-in result
    typedef struct {
        operands_t    op;
        bit           has_exp;
        cplx_result_t res;
    } vector_t;

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [127:0] s_tdata = '0;
    logic [2:0]   s_tuser = '0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [63:0]  m_tdata;
    logic [2:0]   m_tuser;

    cplx_result_t expected_q[$];
    int errors = 0;
    int n_results = 0;
    int idle_cycles = 0;
    int mode_hits[8];
    bit stim_done = 0;
    bit hold_rx = 0;
    bit rx_noidle = 0;
    bit tx_noidle = 0;

    complex_arithmetic_unit dut (.*);

    // clock
    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // signed value to saturated 32-bit part
    function automatic logic [31:0] clamp32(input logic signed [127:0] v, ref bit sat);
        if (v > 128'sd2147483647) begin
            sat = 1;
            return 32'h7FFF_FFFF;
        end
        if (v < -128'sd2147483648) begin
            sat = 1;
            return 32'h8000_0000;
        end
        return v[31:0];
    endfunction

    // truncating division toward zero, quotient magnitude capped at 2^33
    function automatic logic signed [127:0] quot_tz(input logic signed [127:0] num,
                                                    input logic signed [127:0] den);
        logic [127:0] mag;
        logic [127:0] q;
        mag = (num < 0) ? -num : num;
        q = (mag << cau_pkg::FRAC_BITS) / den;
        if (q > (128'd1 << 33)) q = 128'd1 << 33;
        return (num < 0) ? -$signed(q) : $signed(q);
    endfunction

    function automatic logic signed [127:0] shr_tz(input logic signed [127:0] v);
        logic [127:0] mag;
        mag = (v < 0) ? -v : v;
        mag = mag >> cau_pkg::FRAC_BITS;
        return (v < 0) ? -$signed(mag) : $signed(mag);
    endfunction

    // predicted complex result for one operand set
    function automatic cplx_result_t complex_alu(input operands_t op);
        cplx_result_t r;
        logic signed [127:0] ar, ai, br, bi, xr, xi, den;
        bit sat;
        ar = $signed(op.ar); ai = $signed(op.ai);
        br = $signed(op.br); bi = $signed(op.bi);
        r = '{default: '0};
        sat = 0;
        xr = 0; xi = 0;
        case (op.mode)
            cau_pkg::MODE_ADD: begin
                xr = ar + br; xi = ai + bi;
            end
            cau_pkg::MODE_SUB: begin
                xr = ar - br; xi = ai - bi;
            end
            cau_pkg::MODE_MUL: begin
                xr = shr_tz(ar * br - ai * bi);
                xi = shr_tz(ar * bi + ai * br);
            end
            cau_pkg::MODE_DIV: begin
                den = br * br + bi * bi;
                if (den != 0) begin
                    xr = quot_tz(ar * br + ai * bi, den);
                    xi = quot_tz(ai * br - ar * bi, den);
                end
            end
            cau_pkg::MODE_EQ: r.cmp = (ar == br && ai == bi);
            cau_pkg::MODE_NE: r.cmp = !(ar == br && ai == bi);
            default: ;
        endcase
        r.re = clamp32(xr, sat);
        r.im = clamp32(xi, sat);
        if (op.mode == cau_pkg::MODE_DIV && br == 0 && bi == 0) r.st = cau_pkg::ST_DZ;
        else if (sat) r.st = cau_pkg::ST_SAT;
        else r.st = cau_pkg::ST_OK;
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        errors++;
        $display("MISMATCH result %0d %s: got %h expected %h", n_results, what, got, want);
    endtask

    // offer one operand set and wait for its transfer
    task automatic send_item(input operands_t op, input bit has_exp, input cplx_result_t res);
        while (!tx_noidle && $urandom_range(99) < 13) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {op.bi, op.br, op.ai, op.ar};
        s_tuser  <= op.mode;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        expected_q.push_back(has_exp ? res : complex_alu(op));
        mode_hits[op.mode]++;
        @(negedge aclk);
    endtask

    function automatic logic [31:0] rand_part();
        case ($urandom_range(5))
            0: return $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
            1: return $urandom_range(1) ? 32'h0 : 32'hFFFF_FFFF;
            2: return $signed($urandom_range(2000)) - 1000;
            3: return ($signed($urandom_range(200)) - 100) <<< 16;
            default: return $urandom;
        endcase
    endfunction

    // receiver: random idling, a long hold-off on request
    always @(negedge aclk) begin
        if (!aresetn) m_tready <= 1'b0;
        else if (hold_rx) m_tready <= 1'b0;
        else m_tready <= rx_noidle || ($urandom_range(99) >= 13);
    end

    // result checker
    always @(posedge aclk) begin
        cplx_result_t w;
        if (aresetn && m_tvalid && m_tready) begin
            n_results++;
            if (expected_q.size() == 0) begin
                report_mismatch("unexpected transfer", m_tdata[31:0], 32'd0);
            end else begin
                w = expected_q.pop_front();
                if (m_tdata[31:0] !== w.re) report_mismatch("res_real", m_tdata[31:0], w.re);
                if (m_tdata[63:32] !== w.im) report_mismatch("res_imag", m_tdata[63:32], w.im);
                if (m_tuser[0] !== w.cmp)
                    report_mismatch("compare", 32'(m_tuser[0]), 32'(w.cmp));
                if (m_tuser[2:1] !== w.st)
                    report_mismatch("status", 32'(m_tuser[2:1]), 32'(w.st));
            end
        end
    end

    // watchdog on cycles without any transfer, outside the receiver hold-off
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || hold_rx) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Timeout: no transfer for %0d cycles", WATCHDOG_LIMIT);
            $display("** complex_arithmetic_unit: FAILED **");
            $finish;
        end
    end

    initial begin
        vector_t vecs[$];
        operands_t op;
        cplx_result_t zero_res;
        int k;
        zero_res = '{default: '0};
        vecs = '{
            '{'{cau_pkg::MODE_ADD, 32'h7FFF_FFFF, 32'h8000_0000, 32'h1, 32'hFFFF_FFFF}, 1,
              '{32'h7FFF_FFFF, 32'h8000_0000, 1'b0, cau_pkg::ST_SAT}},
            '{'{cau_pkg::MODE_ADD, 32'h0001_0000, 32'h0002_0000, 32'h0003_0000, 32'h0}, 1,
              '{32'h0004_0000, 32'h0002_0000, 1'b0, cau_pkg::ST_OK}},
            '{'{cau_pkg::MODE_SUB, 32'h8000_0000, 32'h0, 32'h1, 32'h0}, 1,
              '{32'h8000_0000, 32'h0, 1'b0, cau_pkg::ST_SAT}},
            '{'{cau_pkg::MODE_SUB, 32'h0005_0000, 32'h0, 32'h0002_0000, 32'h0}, 1,
              '{32'h0003_0000, 32'h0, 1'b0, cau_pkg::ST_OK}},
            '{'{cau_pkg::MODE_MUL, 32'h0002_0000, 32'h0, 32'h0003_0000, 32'h0}, 1,
              '{32'h0006_0000, 32'h0, 1'b0, cau_pkg::ST_OK}},
            '{'{cau_pkg::MODE_MUL, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                32'h8000_0000}, 0, zero_res},
            '{'{cau_pkg::MODE_MUL, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
                32'h7FFF_FFFF}, 0, zero_res},
            '{'{cau_pkg::MODE_MUL, 32'hFFFF_FFFF, 32'h1, 32'h1, 32'hFFFF_FFFF}, 0, zero_res},
            '{'{cau_pkg::MODE_DIV, 32'h0001_0000, 32'h0001_0000, 32'h0, 32'h0}, 1,
              '{32'h0, 32'h0, 1'b0, cau_pkg::ST_DZ}},
            '{'{cau_pkg::MODE_DIV, 32'h0006_0000, 32'h0, 32'h0002_0000, 32'h0}, 1,
              '{32'h0003_0000, 32'h0, 1'b0, cau_pkg::ST_OK}},
            '{'{cau_pkg::MODE_DIV, 32'h7FFF_FFFF, 32'h8000_0000, 32'h1, 32'h0}, 0, zero_res},
            '{'{cau_pkg::MODE_DIV, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
                32'h8000_0000}, 0, zero_res},
            '{'{cau_pkg::MODE_DIV, 32'h1, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF}, 0,
              zero_res},
            '{'{cau_pkg::MODE_EQ, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
                32'h7FFF_FFFF}, 1, '{32'h0, 32'h0, 1'b1, cau_pkg::ST_OK}},
            '{'{cau_pkg::MODE_EQ, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
                32'h7FFF_FFFE}, 1, '{32'h0, 32'h0, 1'b0, cau_pkg::ST_OK}},
            '{'{cau_pkg::MODE_NE, 32'h1234_5678, 32'h0, 32'h1234_5678, 32'h0}, 1,
              '{32'h0, 32'h0, 1'b0, cau_pkg::ST_OK}},
            '{'{cau_pkg::MODE_NE, 32'h1234_5678, 32'h0, 32'h1234_5679, 32'h0}, 1,
              '{32'h0, 32'h0, 1'b1, cau_pkg::ST_OK}},
            '{'{3'd6, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF}, 1,
              zero_res},
            '{'{3'd7, 32'h7FFF_FFFF, 32'h1, 32'h7FFF_FFFF, 32'h1}, 1, zero_res}
        };

        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // directed table
        foreach (vecs[i]) send_item(vecs[i].op, vecs[i].has_exp, vecs[i].res);

        // sender pause until drained
        s_tvalid <= 1'b0;
        while (expected_q.size() != 0) @(negedge aclk);

        for (k = 0; k < N_RANDOM; k++) begin
            // long receiver hold-off while the sender keeps offering
            if (k == 200) begin
                hold_rx = 1;
                fork
                    begin
                        repeat (120) @(negedge aclk);
                        hold_rx = 0;
                    end
                join_none
            end
            tx_noidle = (k >= 400 && k < 600);
            rx_noidle = tx_noidle;
            if (k == 700) begin
                s_tvalid <= 1'b0;
                while (expected_q.size() != 0) @(negedge aclk);
            end
            op.mode = ($urandom_range(19) == 0) ? 3'($urandom_range(7, 6))
                                                : 3'($urandom_range(5));
            op.ar = rand_part(); op.ai = rand_part();
            op.br = rand_part(); op.bi = rand_part();
            // equal operands for compare tests, zero divisor now and then
            if (op.mode >= cau_pkg::MODE_EQ && $urandom_range(1)) begin
                op.br = op.ar; op.bi = op.ai;
            end
            if (op.mode == cau_pkg::MODE_DIV && $urandom_range(15) == 0) begin
                op.br = '0; op.bi = '0;
            end
            send_item(op, 0, zero_res);
        end
        s_tvalid <= 1'b0;
        stim_done = 1;

        k = 0;
        while (expected_q.size() != 0 && k < 100000) begin
            @(negedge aclk);
            k++;
        end
        repeat (LATENCY + 10) @(negedge aclk);

        $display("Covered %0d results: add %0d sub %0d mul %0d div %0d eq %0d ne %0d other %0d",
                 n_results, mode_hits[0], mode_hits[1], mode_hits[2], mode_hits[3],
                 mode_hits[4], mode_hits[5], mode_hits[6] + mode_hits[7]);
        $display("Included saturation, divide by zero, backpressure and drain pauses");
        if (errors == 0 && expected_q.size() == 0) begin
            $display("** complex_arithmetic_unit: PASSED **");
        end else begin
            $display("%0d errors, %0d results missing", errors, expected_q.size());
            $display("** complex_arithmetic_unit: FAILED **");
        end
        $finish;
    end

endmodule

FILE: sim.f
design/cau_pkg.sv
design/cau_front.sv
design/cau_divider.sv
design/cau_back.sv
design/complex_arithmetic_unit.sv
design/cau_checker.sv
verif/tb_top.sv
